/* hdl/vt4x4_pkg.sv */
// ----------------------------------------------------------------------------
// vt4x4_pkg: shared types and constants for the 4x4 vertex transform
// widths of the Q4.12 datapath, register codes and the identity reset matrix
// ----------------------------------------------------------------------------
package vt4x4_pkg;

  localparam int unsigned CompW   = 16;            // one Q4.12 component
  localparam int unsigned FracW   = 12;            // fraction bits
  localparam int unsigned NumComp = 4;             // x, y, z, w
  localparam int unsigned RowW    = CompW * NumComp;
  localparam int unsigned ProdW   = 2 * CompW;     // Q8.24 product
  localparam int unsigned PairW   = ProdW + 1;     // sum of two products
  localparam int unsigned SumW    = ProdW + 2;     // sum of four products
  localparam int unsigned RndW    = SumW - FracW;  // rounded, before clamp
  localparam int unsigned CfgIdxW = 3;

  typedef logic signed [CompW-1:0] comp_t;
  typedef logic signed [ProdW-1:0] prod_t;
  typedef logic signed [PairW-1:0] pair_t;
  typedef logic signed [SumW-1:0]  sum_t;
  typedef logic signed [RndW-1:0]  rnd_t;
  typedef logic [RowW-1:0]         row_t;

  typedef enum logic [CfgIdxW-1:0] {
    CfgRowZero  = 3'd0,
    CfgRowOne   = 3'd1,
    CfgRowTwo   = 3'd2,
    CfgRowThree = 3'd3
  } cfg_idx_e;

  localparam row_t RowZeroRst  = 64'h0000_0000_0000_1000;
  localparam row_t RowOneRst   = 64'h0000_0000_1000_0000;
  localparam row_t RowTwoRst   = 64'h0000_1000_0000_0000;
  localparam row_t RowThreeRst = 64'h1000_0000_0000_0000;

  localparam sum_t  RoundBias = 34'sd2048;
  localparam rnd_t  OutMax    = 22'sd32767;
  localparam rnd_t  OutMin    = -22'sd32768;
  localparam comp_t CompMax   = 16'sh7fff;
  localparam comp_t CompMin   = 16'sh8000;

endpackage

/* hdl/vertex_transform_4x4.sv */
// ----------------------------------------------------------------------------
// vertex_transform_4x4: pipelined 4x4 matrix times homogeneous vertex
// four Q4.12 dot products per vertex, rounded to nearest and saturated
// ----------------------------------------------------------------------------
// usage
//   s_axis: one vertex per request, tdata = {w, z, y, x} packed x in bits 15:0,
//     y 31:16, z 47:32, w 63:48, all signed Q4.12
//   m_axis: one transformed vertex per input request, same packing in tdata,
//     tuser carries the overflow flag (some component was clamped)
//   cfg: write port for the four matrix rows, index 0..3 selects the row,
//     data holds columns 0..3 from the low bits up; other indexes are dropped;
//     write only while the pipeline is empty
// latency: 4 cycles from input request to output valid
//   stage 1 sixteen 16x16 multipliers, stage 2 pairwise adds,
//   stage 3 final add and rounding, stage 4 clamp into the output register
// throughput: one vertex per cycle, set by the fully parallel multiplier bank
// reset: pipeline emptied, matrix returns to identity
// stall: when m_axis_tready is low with a result waiting, the whole pipeline
//   freezes and s_axis_tready drops; nothing is lost or repeated
// ----------------------------------------------------------------------------
module vertex_transform_4x4 (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // input vertex
  input  logic                                  s_axis_tvalid_i,
  output logic                                  s_axis_tready_o,
  input  logic [vt4x4_pkg::RowW-1:0]            s_axis_tdata_i,  // in_x, in_y, in_z, in_w
  // transformed vertex
  output logic                                  m_axis_tvalid_o,
  input  logic                                  m_axis_tready_i,
  output logic [vt4x4_pkg::RowW-1:0]            m_axis_tdata_o,  // out_x, out_y, out_z, out_w
  output logic                                  m_axis_tuser_o,  // overflow
  // matrix row writes
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [vt4x4_pkg::CfgIdxW-1:0]         cfg_index_i,
  input  logic [vt4x4_pkg::RowW-1:0]            cfg_data_i
);
  import vt4x4_pkg::*;

  // matrix rows
  row_t row_q [NumComp];

  // pipeline valid bits, stage 4 is the output register
  logic v1_q, v2_q, v3_q, v4_q;
  logic adv;

  // stage payloads
  prod_t prod_d [NumComp][NumComp];
  prod_t prod_q [NumComp][NumComp];
  pair_t pair_d [NumComp][2];
  pair_t pair_q [NumComp][2];
  rnd_t  rnd_d  [NumComp];
  rnd_t  rnd_q  [NumComp];
  comp_t out_d  [NumComp];
  comp_t out_q  [NumComp];
  logic  ovf_d, ovf_q;

  // the pipeline moves as one whenever the output slot is free or taken
  assign adv             = !v4_q || m_axis_tready_i;
  assign s_axis_tready_o = adv;
  assign cfg_ready_o     = 1'b1;

  // row registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q[0] <= RowZeroRst;
      row_q[1] <= RowOneRst;
      row_q[2] <= RowTwoRst;
      row_q[3] <= RowThreeRst;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgRowZero:  row_q[0] <= cfg_data_i;
        CfgRowOne:   row_q[1] <= cfg_data_i;
        CfgRowTwo:   row_q[2] <= cfg_data_i;
        CfgRowThree: row_q[3] <= cfg_data_i;
        default: ;  // unmapped index, ignored
      endcase
    end
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (adv) begin
      v1_q <= s_axis_tvalid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  // stage 1: all sixteen coefficient-by-component products
  always_comb begin
    comp_t coef;
    comp_t comp;
    for (int r = 0; r < NumComp; r++) begin
      for (int c = 0; c < NumComp; c++) begin
        coef = comp_t'(row_q[r][c*CompW +: CompW]);
        comp = comp_t'(s_axis_tdata_i[c*CompW +: CompW]);
        prod_d[r][c] = coef * comp;
      end
    end
  end

  // stage 2: columns 0+1 and 2+3
  always_comb begin
    for (int r = 0; r < NumComp; r++) begin
      pair_d[r][0] = pair_t'(prod_q[r][0]) + pair_t'(prod_q[r][1]);
      pair_d[r][1] = pair_t'(prod_q[r][2]) + pair_t'(prod_q[r][3]);
    end
  end

  // stage 3: full sum, round half up, drop the fraction
  always_comb begin
    sum_t sum;
    for (int r = 0; r < NumComp; r++) begin
      sum = sum_t'(pair_q[r][0]) + sum_t'(pair_q[r][1]) + RoundBias;
      rnd_d[r] = rnd_t'(sum[SumW-1:FracW]);
    end
  end

  // stage 4: clamp to 16 bits, collect overflow
  always_comb begin
    ovf_d = 1'b0;
    for (int r = 0; r < NumComp; r++) begin
      if (rnd_q[r] > OutMax) begin
        out_d[r] = CompMax;
        ovf_d    = 1'b1;
      end else if (rnd_q[r] < OutMin) begin
        out_d[r] = CompMin;
        ovf_d    = 1'b1;
      end else begin
        out_d[r] = comp_t'(rnd_q[r][CompW-1:0]);
      end
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (adv) begin
      prod_q <= prod_d;
      pair_q <= pair_d;
      rnd_q  <= rnd_d;
      out_q  <= out_d;
      ovf_q  <= ovf_d;
    end
  end

  assign m_axis_tvalid_o = v4_q;
  assign m_axis_tdata_o  = {out_q[3], out_q[2], out_q[1], out_q[0]};
  assign m_axis_tuser_o  = ovf_q;

endmodule

/* hdl/vt4x4_checker.sv */
// ----------------------------------------------------------------------------
// vt4x4_checker: port-level checks for the 4x4 vertex transform
// watches the stream and handshake ports of the top level over time
// ----------------------------------------------------------------------------
module vt4x4_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tready_o,
  input logic                          m_axis_tvalid_o,
  input logic                          m_axis_tready_i,
  input logic [vt4x4_pkg::RowW-1:0]    m_axis_tdata_o,
  input logic                          m_axis_tuser_o
);
  import vt4x4_pkg::*;

  // a stalled result holds still
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("output changed while stalled");

  // input is only held off by a stalled output
  a_ready_only_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> m_axis_tvalid_o && !m_axis_tready_i)
    else $error("input back-pressured without an output stall");

  // overflow means some component sits on a clamp bound
  a_ovf_clamped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o |->
      m_axis_tdata_o[15:0]  == CompMax || m_axis_tdata_o[15:0]  == CompMin ||
      m_axis_tdata_o[31:16] == CompMax || m_axis_tdata_o[31:16] == CompMin ||
      m_axis_tdata_o[47:32] == CompMax || m_axis_tdata_o[47:32] == CompMin ||
      m_axis_tdata_o[63:48] == CompMax || m_axis_tdata_o[63:48] == CompMin)
    else $error("overflow flagged without a clamped component");

endmodule

bind vertex_transform_4x4 vt4x4_checker u_vt4x4_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);
